/* rtl/core/luma_wipe_blend_macros.svh */
// Assertion macros shared by the luma wipe blend RTL.
`ifndef LUMA_WIPE_BLEND_MACROS_SVH
`define LUMA_WIPE_BLEND_MACROS_SVH

// Same-cycle implication, checked on clk and masked during rst.
`define LWB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and masked during rst.
`define LWB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lwb_pkg.sv */
// Types and constants of the luma wipe blend.
`timescale 1ns / 1ps
package lwb_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned QUOT_W     = 16;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION      = 2'd0,
    REG_FRAME_STEP    = 2'd1,
    REG_EDGE_SOFTNESS = 2'd2,
    REG_FIELD_MODE    = 2'd3
  } lwb_reg_t;

  typedef enum logic [1:0] {
    FM_PROGRESSIVE = 2'd0,
    FM_LOWER_FIRST = 2'd1,
    FM_TOP_FIRST   = 2'd2
  } lwb_field_mode_t;

  typedef enum logic [1:0] {
    WC_ZERO = 2'd0,
    WC_ONE  = 2'd1,
    WC_SOFT = 2'd2
  } lwb_wclass_t;

  // Samples and weight class that travel alongside the divider.
  typedef struct packed {
    logic [7:0]  in_y;
    logic [7:0]  in_c;
    logic [7:0]  out_y;
    logic [7:0]  out_c;
    lwb_wclass_t cls;
  } lwb_side_t;

endpackage

/* rtl/core/lwb_if.sv */
// Pixel channel interfaces of the luma wipe blend.
`timescale 1ns / 1ps
interface lwb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  incoming_luma;
  logic [7:0]  incoming_chroma;
  logic [7:0]  outgoing_luma;
  logic [7:0]  outgoing_chroma;
  logic [16:0] map_level;
  logic        line_parity;

  modport source (
    output valid, incoming_luma, incoming_chroma, outgoing_luma, outgoing_chroma,
           map_level, line_parity,
    input  ready
  );
  modport sink (
    input  valid, incoming_luma, incoming_chroma, outgoing_luma, outgoing_chroma,
           map_level, line_parity,
    output ready
  );
endinterface

interface lwb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mixed_luma;
  logic [7:0] mixed_chroma;

  modport source (output valid, mixed_luma, mixed_chroma, input ready);
  modport sink (input valid, mixed_luma, mixed_chroma, output ready);
endinterface

/* rtl/core/lwb_div.sv */
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
module lwb_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [17:0]                    in_diff,
  input  logic [17:0]                    divisor,
  input  lwb_pkg::lwb_side_t             in_side,
  output logic                           out_valid,
  output logic [lwb_pkg::QUOT_W-1:0]     out_quot,
  output lwb_pkg::lwb_side_t             out_side
);
  import lwb_pkg::*;

  logic                v    [0:QUOT_W];
  logic [17:0]         rem  [0:QUOT_W];
  logic [QUOT_W-1:0]   quot [0:QUOT_W];
  lwb_side_t           side [0:QUOT_W];

  assign v[0]    = in_valid;
  assign rem[0]  = in_diff;
  assign quot[0] = '0;
  assign side[0] = in_side;

  // Remainder stays below divisor, so the doubled value fits 19 bits.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [18:0] dbl;
    logic        take;

    assign dbl  = {rem[k], 1'b0};
    assign take = dbl >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? 18'(dbl - {1'b0, divisor}) : dbl[17:0];
        quot[k+1] <= {quot[k][QUOT_W-2:0], take};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[QUOT_W];
  assign out_quot  = quot[QUOT_W];
  assign out_side  = side[QUOT_W];

endmodule

/* rtl/core/luma_wipe_blend.sv */
// Luma wipe blend with smoothstep soft edge: top level.
//
// Usage: pixel pairs enter on pix_in (valid/ready); each one gives exactly
// one blended pair on pix_out (valid/ready), in order. The four registers
// (position, frame step, edge softness, field mode) are written through
// cfg_we / cfg_index / cfg_data while no item is in flight.
// Each pixel pair passes through 22 register stages: field offset, softness
// scaling, edge classification, a 16 stage divider (one quotient bit per
// stage), the square, the smoothstep weight and the mix register.
// Throughput is one item per clock unless pix_out stalls; every stage is a
// register stage. A stall on pix_out freezes the whole pipeline in place and
// pix_in.ready falls with it, so nothing is lost or repeated; pix_in.ready
// stays high while the output register is empty or being taken.
// Synchronous reset empties the pipeline and clears the four registers to
// zero (progressive, hard edge at position zero).
`timescale 1ns / 1ps
module luma_wipe_blend (
  input  logic                              clk,
  input  logic                              rst,
  lwb_in_if.sink                            pix_in,
  lwb_out_if.source                         pix_out,
  input  logic                              cfg_we,
  input  logic [lwb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lwb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lwb_pkg::*;

  `include "luma_wipe_blend_macros.svh"

  // configuration
  logic [16:0] position;
  logic [16:0] frame_step;
  logic [17:0] edge_softness;
  logic [1:0]  field_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      frame_step    <= '0;
      edge_softness <= '0;
      field_mode    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSITION:      position      <= cfg_data[16:0];
        REG_FRAME_STEP:    frame_step    <= cfg_data[16:0];
        REG_EDGE_SOFTNESS: edge_softness <= cfg_data[17:0];
        REG_FIELD_MODE:    field_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v;

  // advance whenever the output register is free or being taken
  assign en           = !out_v || pix_out.ready;
  assign pix_in.ready = en;

  // stage 1: field offset
  logic        v1;
  lwb_side_t   side1;
  logic [16:0] map1;
  logic [17:0] pos_f;
  logic        add_half;

  assign add_half = (field_mode == FM_LOWER_FIRST && !pix_in.line_parity) ||
                    (field_mode == FM_TOP_FIRST && pix_in.line_parity);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= '{in_y:  pix_in.incoming_luma,
                 in_c:  pix_in.incoming_chroma,
                 out_y: pix_in.outgoing_luma,
                 out_c: pix_in.outgoing_chroma,
                 cls:   WC_ZERO};
      map1  <= pix_in.map_level;
      pos_f <= {1'b0, position} + (add_half ? {2'b00, frame_step[16:1]} : 18'd0);
    end
  end

  // stage 2: scale by one plus softness
  logic        v2;
  lwb_side_t   side2;
  logic [16:0] map2;
  logic [20:0] pos_s;
  logic [18:0] scale;
  logic [36:0] scaled;

  assign scale  = {2'b00, ONE_Q16} + {1'b0, edge_softness};
  assign scaled = 37'(pos_f) * 37'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side1;
      map2  <= map1;
      pos_s <= scaled[36:16];
    end
  end

  // stage 3: classify against the soft band
  logic        v3;
  lwb_side_t   side3;
  logic [17:0] diff3;
  logic [20:0] band_hi;
  lwb_wclass_t cls_next;

  assign band_hi = 21'(map2) + 21'(edge_softness);

  always_comb begin
    if (pos_s < 21'(map2)) begin
      cls_next = WC_ZERO;
    end else if (edge_softness == '0 || pos_s >= band_hi) begin
      cls_next = WC_ONE;
    end else begin
      cls_next = WC_SOFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= '{in_y:  side2.in_y,
                 in_c:  side2.in_c,
                 out_y: side2.out_y,
                 out_c: side2.out_c,
                 cls:   cls_next};
      diff3 <= 18'(pos_s - 21'(map2));
    end
  end

  // stages 4 to 19: t = (diff << 16) / softness
  logic              vd;
  logic [QUOT_W-1:0] t_d;
  lwb_side_t         side_d;

  lwb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_diff   (diff3),
    .divisor   (edge_softness),
    .in_side   (side3),
    .out_valid (vd),
    .out_quot  (t_d),
    .out_side  (side_d)
  );

  // stage 20: square
  logic              v20;
  lwb_side_t         side20;
  logic [QUOT_W-1:0] t20;
  logic [15:0]       t2;
  logic [31:0]       sq;

  assign sq = 32'(t_d) * 32'(t_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      v20 <= 1'b0;
    end else if (en) begin
      v20 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side20 <= side_d;
      t20    <= t_d;
      t2     <= sq[31:16];
    end
  end

  // stage 21: smoothstep weight
  logic        v21;
  lwb_side_t   side21;
  logic [16:0] w21;
  logic [17:0] fac;
  logic [33:0] wprod;
  logic [16:0] w_next;

  assign fac   = THREE_Q16 - {1'b0, t20, 1'b0};
  assign wprod = 34'(t2) * 34'(fac);

  always_comb begin
    case (side20.cls)
      WC_ZERO: w_next = '0;
      WC_ONE:  w_next = ONE_Q16;
      WC_SOFT: w_next = wprod[32:16];
      default: w_next = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v21 <= 1'b0;
    end else if (en) begin
      v21 <= v20;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side21 <= side20;
      w21    <= w_next;
    end
  end

  // stage 22: mix as b + (a - b) * w, exact and non-negative, then truncated
  logic signed [8:0]  dy;
  logic signed [8:0]  dc;
  logic signed [17:0] ws;
  logic signed [26:0] py;
  logic signed [26:0] pc;
  logic signed [26:0] ay;
  logic signed [26:0] ac;
  logic [7:0]         mixed_y;
  logic [7:0]         mixed_c;

  assign dy = $signed({1'b0, side21.in_y}) - $signed({1'b0, side21.out_y});
  assign dc = $signed({1'b0, side21.in_c}) - $signed({1'b0, side21.out_c});
  assign ws = $signed({1'b0, w21});
  assign py = 27'(dy) * 27'(ws);
  assign pc = 27'(dc) * 27'(ws);
  assign ay = py + $signed({3'b000, side21.out_y, 16'h0000});
  assign ac = pc + $signed({3'b000, side21.out_c, 16'h0000});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v21;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mixed_y <= ay[23:16];
      mixed_c <= ac[23:16];
    end
  end

  assign pix_out.valid        = out_v;
  assign pix_out.mixed_luma   = mixed_y;
  assign pix_out.mixed_chroma = mixed_c;

  `LWB_ASSERT_IMP(a_soft_needs_width, v3 && side3.cls == WC_SOFT, edge_softness != '0, "soft class with zero softness")
  `LWB_ASSERT_IMP(a_diff_in_band, v3 && side3.cls == WC_SOFT, diff3 < edge_softness, "divider input not below softness")
  `LWB_ASSERT_IMP(a_weight_range, v21, w21 <= ONE_Q16, "blend weight above one")
  `LWB_ASSERT_NXT(a_stall_freezes, !en && v21, v21 && out_v, "stage advanced during stall")

endmodule
